### rtl/scm_pkg.sv
// Shared types and constants for the scancode to crosspoint mapper.
package scm_pkg;

    // Store sizing and the highest code that is treated as a key
    localparam int CODE_COUNT   = 256;
    localparam int CODE_AW      = $clog2(CODE_COUNT);
    localparam int MAX_KEY_CODE = 132;
    localparam int SLOT_COUNT   = 4;

    // Special scancode bytes
    localparam logic [7:0] BYTE_NONE   = 8'h00;
    localparam logic [7:0] BYTE_BREAK  = 8'hF0;
    localparam logic [7:0] BYTE_EXT    = 8'hE0;
    localparam logic [7:0] BYTE_PAUSE  = 8'hE1;
    localparam logic [7:0] BYTE_MACRO1 = 8'h05;
    localparam logic [7:0] BYTE_MACRO2 = 8'h06;
    localparam logic [7:0] BYTE_MACRO3 = 8'h04;
    localparam logic [7:0] BYTE_MACRO4 = 8'h0C;

    // Input item kind carried on tuser
    typedef enum logic {
        FUNC_SCAN      = 1'b0,
        FUNC_MAP_WRITE = 1'b1
    } t_func;

    // Map slots held for every scancode
    typedef enum logic [1:0] {
        SLOT_PLAIN_KEY = 2'd0,
        SLOT_PLAIN_MOD = 2'd1,
        SLOT_EXT_KEY   = 2'd2,
        SLOT_EXT_MOD   = 2'd3
    } t_slot;

    // Input tdata layout, first field in the highest bits
    typedef struct packed {
        logic [5:0] pad;
        logic [6:0] entry_address;
        logic       entry_present;
        logic [1:0] entry_slot;
        logic [7:0] entry_code;
        logic [7:0] scan_byte;
    } t_in_data;

    // Output tdata layout
    typedef struct packed {
        logic       switch_close;
        logic [6:0] switch_address;
    } t_out_data;

    // One map entry as stored
    typedef struct packed {
        logic       present;
        logic [6:0] address;
    } t_map_entry;

    // Held-key store word, one per scancode
    typedef struct packed {
        logic ext;
        logic plain;
    } t_held;

    // Key code passed from the decode stage to the emit stage
    typedef struct packed {
        logic [CODE_AW-1:0] code;
        logic               release_key;
        logic               ext;
    } t_key_item;

endpackage

### rtl/scancode_to_crosspoint_mapper.sv
// Top level: PS/2 set-2 scancode stream to crosspoint switch command stream.
// A key byte is registered as a key item with its map RAM read, then loaded into the
// two-entry output buffer. Throughput: one byte per cycle while the output is not stalled;
// a byte giving two commands holds back the next key byte until the buffer has room.
// Reset (synchronous, active low) clears prefix flags and the output buffer, then tready
// stays low while all 256 held-key store entries are cleared; map RAMs are not cleared.
module scancode_to_crosspoint_mapper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata: scan_byte[7:0], entry_code[15:8], entry_slot[17:16],
    //        entry_present[18], entry_address[25:19], zero[31:26]
    input  logic [31:0] i_s_tdata,
    // tuser: func[0]
    input  logic        i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata: switch_address[6:0], switch_close[7]
    output logic [7:0]  o_m_tdata,
    output logic        o_m_tlast
);
    import scm_pkg::*;

    t_in_data           in_data;
    t_func              in_func;
    logic               in_accept;
    logic               map_wr;
    logic               dec_ready;
    logic               clearing;
    logic               rd_en;
    logic [CODE_AW-1:0] rd_addr;
    logic               item_valid;
    t_key_item          item;
    logic               go;
    t_map_entry         map_rd [SLOT_COUNT];
    t_map_entry         wr_entry;
    t_out_data          out_data;
    logic [1:0]         held_rd;
    logic               held_wr_en;
    logic [CODE_AW-1:0] held_wr_addr;
    logic [1:0]         held_wr_data;

    assign in_data   = t_in_data'(i_s_tdata);
    assign in_func   = t_func'(i_s_tuser);
    assign in_accept = i_s_tvalid && o_s_tready;

    // No transfers while the held-key store is being cleared
    assign o_s_tready = dec_ready && !clearing;

    // Map writes beyond the stores are dropped
    assign map_wr = in_accept && in_func == FUNC_MAP_WRITE
                    && ({1'b0, in_data.entry_code} < 9'(CODE_COUNT));
    assign wr_entry.present = in_data.entry_present;
    assign wr_entry.address = in_data.entry_address;

    scm_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_func       (in_func),
        .i_scan_byte  (in_data.scan_byte),
        .i_go         (go),
        .o_ready      (dec_ready),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .o_item_valid (item_valid),
        .o_item       (item)
    );

    // One map RAM per slot, all read at the same code
    for (genvar s = 0; s < SLOT_COUNT; s++) begin : g_map
        logic [7:0] rd_data;

        scm_ram #(
            .WIDTH (8),
            .DEPTH (CODE_COUNT)
        ) u_ram (
            .i_clk     (i_clk),
            .i_wr_en   (map_wr && in_data.entry_slot == 2'(s)),
            .i_wr_addr (in_data.entry_code[CODE_AW-1:0]),
            .i_wr_data (wr_entry),
            .i_rd_en   (rd_en),
            .i_rd_addr (rd_addr),
            .o_rd_data (rd_data)
        );

        assign map_rd[s] = t_map_entry'(rd_data);
    end

    // Held-key store, read alongside the map
    scm_ram #(
        .WIDTH (2),
        .DEPTH (CODE_COUNT)
    ) u_held_ram (
        .i_clk     (i_clk),
        .i_wr_en   (held_wr_en),
        .i_wr_addr (held_wr_addr),
        .i_wr_data (held_wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (held_rd)
    );

    scm_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item_valid   (item_valid),
        .i_item         (item),
        .i_map          (map_rd),
        .i_rd_en        (rd_en),
        .i_rd_addr      (rd_addr),
        .i_held         (held_rd),
        .o_held_wr_en   (held_wr_en),
        .o_held_wr_addr (held_wr_addr),
        .o_held_wr_data (held_wr_data),
        .o_clearing     (clearing),
        .o_go           (go),
        .o_m_tvalid     (o_m_tvalid),
        .i_m_tready     (i_m_tready),
        .o_m_tdata      (out_data),
        .o_m_tlast      (o_m_tlast)
    );

    assign o_m_tdata = out_data;

endmodule

### rtl/scm_ram.sv
// Generic single write port RAM with a registered read port.
module scm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write and registered read; read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/scm_decode.sv
// Byte decode: prefix flags, byte filtering and the key item register.
module scm_decode (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  scm_pkg::t_func             i_func,
    input  logic [7:0]                 i_scan_byte,
    input  logic                       i_go,
    output logic                       o_ready,
    output logic                       o_rd_en,
    output logic [scm_pkg::CODE_AW-1:0] o_rd_addr,
    output logic                       o_item_valid,
    output scm_pkg::t_key_item         o_item
);
    import scm_pkg::*;

    logic      r_break;
    logic      r_ext;
    logic      r_item_valid;
    t_key_item r_item;
    logic      n_break;
    logic      n_ext;
    logic      is_key;
    logic      in_range;

    // Stage is free when empty or when its item moves on this cycle
    assign o_ready = !r_item_valid || i_go;

    assign in_range = ({1'b0, i_scan_byte} < 9'(CODE_COUNT));

    // Classify the byte and work out the prefix flags
    always_comb begin
        is_key  = 1'b0;
        n_break = r_break;
        n_ext   = r_ext;
        if (i_accept && i_func == FUNC_SCAN) begin
            priority if (i_scan_byte == BYTE_NONE) begin
                is_key = 1'b0;
            end else if (i_scan_byte == BYTE_BREAK) begin
                n_break = 1'b1;
            end else if (i_scan_byte == BYTE_EXT) begin
                n_ext = 1'b1;
            end else if (i_scan_byte == BYTE_PAUSE || i_scan_byte == BYTE_MACRO1
                         || i_scan_byte == BYTE_MACRO2 || i_scan_byte == BYTE_MACRO3
                         || i_scan_byte == BYTE_MACRO4) begin
                is_key = 1'b0;
            end else if ({1'b0, i_scan_byte} > 9'(MAX_KEY_CODE)) begin
                is_key = 1'b0;
            end else begin
                // key code: flags cleared whether or not it is in the stores
                is_key  = in_range;
                n_break = 1'b0;
                n_ext   = 1'b0;
            end
        end
    end

    // Map read is issued with the key code so entries land with the item
    assign o_rd_en   = is_key;
    assign o_rd_addr = i_scan_byte[CODE_AW-1:0];

    // Flags and item valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_break      <= 1'b0;
            r_ext        <= 1'b0;
            r_item_valid <= 1'b0;
        end else begin
            r_break <= n_break;
            r_ext   <= n_ext;
            if (o_ready) begin
                r_item_valid <= is_key;
            end
        end
    end

    // Item payload
    always_ff @(posedge i_clk) begin
        if (is_key) begin
            r_item.code        <= i_scan_byte[CODE_AW-1:0];
            r_item.release_key <= r_break;
            r_item.ext         <= r_ext;
        end
    end

    assign o_item_valid = r_item_valid;
    assign o_item       = r_item;

endmodule

### rtl/scm_emit.sv
// Emit stage: held-key store control, make/break decision and the two-entry result buffer.
module scm_emit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_item_valid,
    input  scm_pkg::t_key_item          i_item,
    input  scm_pkg::t_map_entry         i_map [scm_pkg::SLOT_COUNT],
    input  logic                        i_rd_en,
    input  logic [scm_pkg::CODE_AW-1:0] i_rd_addr,
    input  logic [1:0]                  i_held,
    output logic                        o_held_wr_en,
    output logic [scm_pkg::CODE_AW-1:0] o_held_wr_addr,
    output logic [1:0]                  o_held_wr_data,
    output logic                        o_clearing,
    output logic                        o_go,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output scm_pkg::t_out_data          o_m_tdata,
    output logic                        o_m_tlast
);
    import scm_pkg::*;

    logic               r_clearing;
    logic [CODE_AW-1:0] r_clr_addr;
    logic               r_fwd;
    t_held              r_fwd_word;
    logic [1:0]         r_cnt;
    t_out_data          r_head;
    logic               r_head_last;
    t_out_data          r_tail;
    logic [1:0]         n_cnt;
    t_out_data          n_head;
    logic               n_head_last;
    t_out_data          n_tail;
    t_map_entry         key_e;
    t_map_entry         mod_e;
    t_held              held_word;
    t_held              new_word;
    logic               held_now;
    logic               emit;
    logic               room;
    logic               take;
    logic               load;

    // Held bits for this key; a write by the previous item to the same code is forwarded
    assign held_word = r_fwd ? r_fwd_word : t_held'(i_held);

    // Pick the entries and held bit for this key
    assign key_e    = i_item.ext ? i_map[SLOT_EXT_KEY] : i_map[SLOT_PLAIN_KEY];
    assign mod_e    = i_item.ext ? i_map[SLOT_EXT_MOD] : i_map[SLOT_PLAIN_MOD];
    assign held_now = i_item.ext ? held_word.ext : held_word.plain;

    // Held word after this key goes out
    always_comb begin
        new_word = held_word;
        if (i_item.ext) begin
            new_word.ext = !i_item.release_key;
        end else begin
            new_word.plain = !i_item.release_key;
        end
    end

    // A make on a held key is dropped; a break always goes out if mapped
    assign emit = key_e.present && (i_item.release_key || !held_now);
    assign take = o_m_tvalid && i_m_tready;
    assign room = (r_cnt == 2'd0) || (r_cnt == 2'd1 && take);
    assign o_go = i_item_valid && (!emit || room);
    assign load = o_go && emit;

    // Result buffer next state
    always_comb begin
        n_cnt       = r_cnt;
        n_head      = r_head;
        n_head_last = r_head_last;
        n_tail      = r_tail;
        priority if (load) begin
            n_tail.switch_address = key_e.address;
            n_tail.switch_close   = !i_item.release_key;
            if (mod_e.present) begin
                n_head.switch_address = mod_e.address;
                n_head.switch_close   = !i_item.release_key;
                n_head_last           = 1'b0;
                n_cnt                 = 2'd2;
            end else begin
                n_head      = n_tail;
                n_head_last = 1'b1;
                n_cnt       = 2'd1;
            end
        end else if (take) begin
            // the second entry is always the last of its run
            n_head      = r_tail;
            n_head_last = 1'b1;
            n_cnt       = r_cnt - 2'd1;
        end else begin
            n_cnt = r_cnt;
        end
    end

    // Clearing pass over the held-key store after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + CODE_AW'(1);
            if (r_clr_addr == CODE_AW'(CODE_COUNT - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Held-key store write port
    assign o_held_wr_en   = r_clearing || load;
    assign o_held_wr_addr = r_clearing ? r_clr_addr : i_item.code;
    assign o_held_wr_data = r_clearing ? 2'b00 : new_word;
    assign o_clearing     = r_clearing;

    // Forward flag: next item reads the code being written in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= load && (i_rd_addr == i_item.code);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_word <= new_word;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // Buffer payload
    always_ff @(posedge i_clk) begin
        r_head      <= n_head;
        r_head_last <= n_head_last;
        r_tail      <= n_tail;
    end

    assign o_m_tvalid = (r_cnt != 2'd0);
    assign o_m_tdata  = r_head;
    assign o_m_tlast  = r_head_last;

endmodule

### rtl/scm_checker.sv
// Port-level checks on the mapper's output stream, bound to the top level.
module scm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic       o_m_tlast
);

    // A stalled command holds its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output changed while stalled");

    // The key command follows its modifier straight away
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !o_m_tlast |=> o_m_tvalid)
        else $error("modifier not followed by key command");

    // Modifier and key of one run share the same open/close direction
    a_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !o_m_tlast |=> o_m_tdata[7] == $past(o_m_tdata[7]))
        else $error("direction differs within a run");

    // Output buffer is empty straight after reset
    a_rst: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind scancode_to_crosspoint_mapper scm_checker u_scm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

### sim/scancode_to_crosspoint_mapper_test.sv
// Self-checking testbench for the scancode to crosspoint mapper: directed and random byte streams.
module scancode_to_crosspoint_mapper_test;
    import scm_pkg::*;

    // One expected switch command with its end-of-run marker
    typedef struct packed {
        t_out_data data;
        logic      last;
    } t_switch_cmd;

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    // tdata: scan_byte, entry_code, entry_slot, entry_present, entry_address, zero pad
    logic [31:0] i_s_tdata  = '0;
    // tuser: func
    logic        i_s_tuser  = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    // tdata: switch_address, switch_close
    logic [7:0]  o_m_tdata;
    logic        o_m_tlast;

    // Own copy of the mapper state
    logic                             brk_pending;
    logic                             ext_pending;
    logic [CODE_COUNT-1:0]            plain_down;
    logic [CODE_COUNT-1:0]            ext_down;
    t_map_entry                       map_copy [CODE_COUNT*SLOT_COUNT];
    logic [CODE_COUNT*SLOT_COUNT-1:0] map_written;
    t_switch_cmd                      cmd_queue [$];

    logic [7:0] key_pool [16];
    bit         src_idle = 1'b1;
    bit         snk_idle = 1'b1;
    int         n_useful;
    int         n_writes;
    int         n_keys;
    int         n_ignored;
    int         n_cmds;
    int         n_mismatch;

    scancode_to_crosspoint_mapper dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop in case the handshakes lock up
    initial begin : watchdog
        #4000000;
        $display("Mismatches found");
        $finish;
    end

    function automatic int draw_gap(bit idle_on);
        if (!idle_on || $urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 14);
    endfunction

    function automatic int map_index(logic [7:0] code, t_slot slot);
        return int'(code) * SLOT_COUNT + int'(slot);
    endfunction

    // Bytes that do not act as a key code; the prefix bytes also fall in this set
    function automatic bit byte_ignored(logic [7:0] b);
        return b == BYTE_NONE || b == BYTE_PAUSE || b == BYTE_MACRO1 || b == BYTE_MACRO2 ||
               b == BYTE_MACRO3 || b == BYTE_MACRO4 || b > MAX_KEY_CODE;
    endfunction

    function automatic logic [7:0] pick_code();
        logic [7:0] c;
        if ($urandom_range(0, 7) == 0) begin
            c = 8'($urandom_range(1, MAX_KEY_CODE));
            return c;
        end
        return key_pool[$urandom_range(0, 15)];
    endfunction

    function automatic logic [7:0] pick_ignored();
        logic [7:0] c;
        case ($urandom_range(0, 6))
            0: c = BYTE_NONE;
            1: c = BYTE_PAUSE;
            2: c = BYTE_MACRO1;
            3: c = BYTE_MACRO2;
            4: c = BYTE_MACRO3;
            5: c = BYTE_MACRO4;
            default: begin
                c = 8'($urandom_range(MAX_KEY_CODE + 1, 255));
                if (c == BYTE_BREAK || c == BYTE_EXT) c = 8'hFF;
            end
        endcase
        return c;
    endfunction

    task automatic note_mismatch(string msg);
        n_mismatch++;
        if (n_mismatch <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // Works out the switch commands an accepted transfer causes
    task automatic predict_commands(t_func f, t_in_data d);
        t_map_entry  key_e;
        t_map_entry  mod_e;
        logic        held;
        logic        brk;
        t_switch_cmd c;
        if (f == FUNC_MAP_WRITE) begin
            if (d.entry_code < CODE_COUNT) begin
                map_copy[map_index(d.entry_code, t_slot'(d.entry_slot))] =
                    {d.entry_present, d.entry_address};
                map_written[map_index(d.entry_code, t_slot'(d.entry_slot))] = 1'b1;
            end
            return;
        end
        if (d.scan_byte == BYTE_BREAK) begin
            brk_pending = 1'b1;
            return;
        end
        if (d.scan_byte == BYTE_EXT) begin
            ext_pending = 1'b1;
            return;
        end
        if (byte_ignored(d.scan_byte)) return;

        brk = brk_pending;
        if (ext_pending) begin
            key_e = map_copy[map_index(d.scan_byte, SLOT_EXT_KEY)];
            mod_e = map_copy[map_index(d.scan_byte, SLOT_EXT_MOD)];
            held  = ext_down[d.scan_byte];
        end else begin
            key_e = map_copy[map_index(d.scan_byte, SLOT_PLAIN_KEY)];
            mod_e = map_copy[map_index(d.scan_byte, SLOT_PLAIN_MOD)];
            held  = plain_down[d.scan_byte];
        end
        // A make of a key already down is dropped; a break always goes out
        if (key_e.present && !(!brk && held)) begin
            if (mod_e.present) begin
                c.data.switch_address = mod_e.address;
                c.data.switch_close   = !brk;
                c.last                = 1'b0;
                cmd_queue.push_back(c);
            end
            if (ext_pending) ext_down[d.scan_byte] = !brk;
            else plain_down[d.scan_byte] = !brk;
            c.data.switch_address = key_e.address;
            c.data.switch_close   = !brk;
            c.last                = 1'b1;
            cmd_queue.push_back(c);
        end
        brk_pending = 1'b0;
        ext_pending = 1'b0;
    endtask

    // Presents one item after a random gap and waits for its transfer
    task automatic send_item(t_func f, t_in_data d);
        int gap;
        gap = draw_gap(src_idle);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= d;
        i_s_tuser  <= f;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_commands(f, d);
    endtask

    task automatic send_write(logic [7:0] code, t_slot slot, logic present, logic [6:0] addr);
        t_in_data d;
        d               = '0;
        d.entry_code    = code;
        d.entry_slot    = slot;
        d.entry_present = present;
        d.entry_address = addr;
        n_writes++;
        n_useful++;
        send_item(FUNC_MAP_WRITE, d);
    endtask

    // Loads any map slot a key byte would read before it is sent
    task automatic send_scan(logic [7:0] b);
        t_in_data d;
        t_slot    ks;
        t_slot    ms;
        if (b != BYTE_BREAK && b != BYTE_EXT && byte_ignored(b)) begin
            n_ignored++;
        end else begin
            n_useful++;
            if (b != BYTE_BREAK && b != BYTE_EXT) begin
                if (ext_pending) begin
                    ks = SLOT_EXT_KEY;
                    ms = SLOT_EXT_MOD;
                end else begin
                    ks = SLOT_PLAIN_KEY;
                    ms = SLOT_PLAIN_MOD;
                end
                if (!map_written[map_index(b, ks)])
                    send_write(b, ks, $urandom_range(0, 4) != 0, 7'($urandom_range(0, 127)));
                if (!map_written[map_index(b, ms)])
                    send_write(b, ms, 1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)));
                n_keys++;
            end
        end
        d           = '0;
        d.scan_byte = b;
        send_item(FUNC_SCAN, d);
    endtask

    // A well-formed make or break, plain or extended
    task automatic random_keystroke();
        logic [7:0] code;
        code = pick_code();
        if ($urandom_range(0, 3) == 0) send_scan(BYTE_EXT);
        if ($urandom_range(0, 1) == 1) send_scan(BYTE_BREAK);
        send_scan(code);
    endtask

    // Input goes idle until every expected command has been seen
    task automatic wait_for_commands();
        i_s_tvalid <= 1'b0;
        while (cmd_queue.size() != 0) @(posedge i_clk);
    endtask

    // Extremes of the map fields, each special ignored byte and one out-of-range byte, repeats and prefixes
    task automatic test_directed();
        send_write(8'h84, SLOT_PLAIN_KEY, 1'b1, 7'h7F);
        send_write(8'h84, SLOT_PLAIN_MOD, 1'b1, 7'h00);
        send_write(8'h84, SLOT_EXT_KEY,   1'b1, 7'h55);
        send_write(8'h84, SLOT_EXT_MOD,   1'b0, 7'h2A);
        send_write(8'h01, SLOT_PLAIN_KEY, 1'b0, 7'h00);
        send_write(8'h01, SLOT_PLAIN_MOD, 1'b1, 7'h03);
        send_scan(BYTE_NONE);
        send_scan(BYTE_PAUSE);
        send_scan(BYTE_MACRO1);
        send_scan(BYTE_MACRO2);
        send_scan(BYTE_MACRO3);
        send_scan(BYTE_MACRO4);
        send_scan(8'h85);
        // make, repeated make while held, break, break of a released key
        send_scan(8'h84);
        send_scan(8'h84);
        send_scan(BYTE_BREAK);
        send_scan(8'h84);
        send_scan(BYTE_BREAK);
        send_scan(8'h84);
        // extended make without a modifier, then an unmapped plain key
        send_scan(BYTE_EXT);
        send_scan(8'h84);
        send_scan(8'h01);
        send_scan(BYTE_EXT);
        send_scan(BYTE_BREAK);
        send_scan(8'h84);
    endtask

    task automatic test_keystrokes(int count);
        int goal;
        goal = n_useful + count;
        foreach (key_pool[i]) key_pool[i] = 8'($urandom_range(1, MAX_KEY_CODE));
        while (n_useful < goal) random_keystroke();
    endtask

    // Sender holds off until the output side has caught up
    task automatic test_drain_pause();
        repeat (8) random_keystroke();
        wait_for_commands();
        repeat (8) random_keystroke();
    endtask

    // Stray bytes, remaps and broken prefix sequences mixed with keystrokes
    task automatic test_noise_mix(int count);
        int goal;
        goal     = n_useful + count;
        snk_idle = 1'b0;
        while (n_useful < goal) begin
            case ($urandom_range(0, 5))
                0: send_scan(8'($urandom_range(0, 255)));
                1: send_write(8'($urandom_range(0, 255)), t_slot'($urandom_range(0, 3)),
                              1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)));
                2: begin
                    send_scan(BYTE_BREAK);
                    send_scan(BYTE_BREAK);
                    send_scan(pick_code());
                end
                3: begin
                    send_scan(BYTE_EXT);
                    send_scan(pick_ignored());
                    send_scan(pick_code());
                end
                4: begin
                    if ($urandom_range(0, 1) == 1) send_scan(BYTE_EXT);
                    else send_scan(BYTE_BREAK);
                    send_write(pick_code(), t_slot'($urandom_range(0, 3)),
                               $urandom_range(0, 3) != 0, 7'($urandom_range(0, 127)));
                    send_scan(pick_code());
                end
                default: random_keystroke();
            endcase
        end
        snk_idle = 1'b1;
    endtask

    // Back-to-back transfers, first with no stalls, then with output stalls only
    task automatic test_full_rate(int count);
        int goal;
        src_idle = 1'b0;
        snk_idle = 1'b0;
        goal     = n_useful + count / 2;
        while (n_useful < goal) random_keystroke();
        snk_idle = 1'b1;
        goal     = n_useful + count / 2;
        while (n_useful < goal) random_keystroke();
        src_idle = 1'b1;
    endtask

    // Output side: random stall before each command
    initial begin : switch_sink
        int gap;
        forever begin
            gap = draw_gap(snk_idle);
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
        end
    end

    // Compares every command transfer with the oldest expectation
    initial begin : command_check
        t_switch_cmd want;
        t_out_data   got;
        forever begin
            @(posedge i_clk);
            if (o_m_tvalid === 1'b1 && i_m_tready) begin
                got = o_m_tdata;
                n_cmds++;
                if (cmd_queue.size() == 0) begin
                    note_mismatch($sformatf("unexpected command addr %0h close %0b last %0b",
                                            got.switch_address, got.switch_close, o_m_tlast));
                end else begin
                    want = cmd_queue.pop_front();
                    if (got.switch_address !== want.data.switch_address)
                        note_mismatch($sformatf("switch_address expected %0h, got %0h",
                                                want.data.switch_address, got.switch_address));
                    if (got.switch_close !== want.data.switch_close)
                        note_mismatch($sformatf("switch_close expected %0b, got %0b",
                                                want.data.switch_close, got.switch_close));
                    if (o_m_tlast !== want.last)
                        note_mismatch($sformatf("tlast expected %0b, got %0b",
                                                want.last, o_m_tlast));
                end
            end
        end
    end

    initial begin : run_tests
        int guard;
        brk_pending = 1'b0;
        ext_pending = 1'b0;
        plain_down  = '0;
        ext_down    = '0;
        map_written = '0;
        foreach (map_copy[i]) map_copy[i] = '0;
        n_useful   = 0;
        n_writes   = 0;
        n_keys     = 0;
        n_ignored  = 0;
        n_cmds     = 0;
        n_mismatch = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_keystrokes(900);
        test_drain_pause();
        test_noise_mix(500);
        test_full_rate(400);
        i_s_tvalid <= 1'b0;

        // Let the last commands out, then a short quiet spell for strays
        guard = 0;
        while (cmd_queue.size() != 0 && guard < 10000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
        for (int i = 0; i < cmd_queue.size(); i++)
            note_mismatch("expected command never arrived");

        $display("Run sent %0d map writes, %0d key bytes and %0d ignored bytes,",
                 n_writes, n_keys, n_ignored);
        $display("checking %0d switch commands under random stalls on both sides.", n_cmds);
        if (n_mismatch == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
